>>> rtl/uvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Word types, register indexes and table geometry shared by the sphere block.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_SEGMENTS = 255;
  localparam int SEG_W        = 8;
  localparam int TAB_DEPTH    = MAX_SEGMENTS / 2 + 1;
  localparam int TAB_AW       = $clog2(TAB_DEPTH);
  localparam int TRIG_W       = 31;
  localparam int CFG_AW       = 3;

  localparam logic [33:0]       PI32  = 34'd13493037705;
  localparam logic [TRIG_W-1:0] ONE30 = 31'h4000_0000;

  localparam logic [CFG_AW-1:0] REG_SEGMENT_COUNT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RADIUS        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CENTER_Z      = 3'd4;

  typedef struct packed {
    logic [7:0] ring_index;
    logic [7:0] pole_index;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        vertex_slot;
    logic               quad_valid;
    logic [15:0]        tri_upper;
    logic [15:0]        tri_lower_next;
    logic [15:0]        tri_upper_next;
  } out_word_t;

  typedef struct packed {
    logic              en;
    logic [TAB_AW-1:0] addr_a;
    logic [TAB_AW-1:0] addr_b;
  } tab_rd_t;

  typedef struct packed {
    logic [TRIG_W-1:0] sin_a;
    logic [TRIG_W-1:0] cos_a;
    logic [TRIG_W-1:0] sin_b;
    logic [TRIG_W-1:0] cos_b;
  } tab_data_t;

endpackage
`default_nettype wire

>>> rtl/uvs_trig_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere sine/cosine table
// Builds sin and cos of s*pi/(2N) for s = 0..N/2 in Q1.30 with a shared
// multiplier, a bit-serial divider for the angle step and reciprocal
// multiplies for the series terms, and serves two registered reads.
// ----------------------------------------------------------------------------
module uvs_trig_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [uvs_pkg::SEG_W-1:0] seg_n,
  input  wire logic                      restart,
  output logic                           busy,
  input  wire uvs_pkg::tab_rd_t          rd,
  output uvs_pkg::tab_data_t             rd_data
);
  import uvs_pkg::*;

  typedef enum logic [7:0] {
    FS_DIV  = 8'b0000_0001,
    FS_X2M  = 8'b0000_0010,
    FS_X2   = 8'b0000_0100,
    FS_TM   = 8'b0000_1000,
    FS_TL   = 8'b0001_0000,
    FS_TD   = 8'b0010_0000,
    FS_ACC  = 8'b0100_0000,
    FS_IDLE = 8'b1000_0000
  } fill_state_t;

  typedef struct packed {
    logic [5:0]  sh;
    logic [31:0] m;
  } recip_t;

  // floor(t / d) = (t * m) >> sh for every 31-bit t
  function automatic recip_t term_recip(input logic cos_ph, input logic [2:0] k);
    recip_t r;
    unique case ({cos_ph, k})
      4'b0_001: r = '{sh: 6'd34, m: 32'd2863311531};
      4'b0_010: r = '{sh: 6'd36, m: 32'd3435973837};
      4'b0_011: r = '{sh: 6'd37, m: 32'd3272356036};
      4'b0_100: r = '{sh: 6'd38, m: 32'd3817748708};
      4'b0_101: r = '{sh: 6'd38, m: 32'd2498890064};
      4'b0_110: r = '{sh: 6'd39, m: 32'd3524075731};
      4'b1_001: r = '{sh: 6'd32, m: 32'd2147483648};
      4'b1_010: r = '{sh: 6'd35, m: 32'd2863311531};
      4'b1_011: r = '{sh: 6'd36, m: 32'd2290649225};
      4'b1_100: r = '{sh: 6'd37, m: 32'd2454267027};
      4'b1_101: r = '{sh: 6'd38, m: 32'd3054198967};
      4'b1_110: r = '{sh: 6'd39, m: 32'd4164816772};
      default:  r = '{sh: 6'd0, m: 32'd1};
    endcase
    return r;
  endfunction

  function automatic logic [TRIG_W-1:0] clamp30(input logic signed [32:0] v);
    logic [TRIG_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b0, ONE30})) begin
      r = ONE30;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

  fill_state_t              state_r;
  logic [5:0]               cnt_r;
  logic [10:0]              prem_r;
  logic [30:0]              pq_r;
  logic [30:0]              axq_r;
  logic [11:0]              axr_r;
  logic [TAB_AW-1:0]        ent_r;
  logic [30:0]              x2_r;
  logic [30:0]              t_r;
  logic signed [32:0]       acc_r;
  logic [62:0]              prod_r;
  logic [2:0]               k_r;
  logic                     cos_r;
  logic [TRIG_W-1:0]        sv_r;
  logic [2*TRIG_W-1:0]      mem [TAB_DEPTH];
  logic [2*TRIG_W-1:0]      rda_r;
  logic [2*TRIG_W-1:0]      rdb_r;

  logic [10:0]              dvsr;
  logic [11:0]              pshift;
  logic                     pbit;
  recip_t                   rc;
  logic [30:0]              tq;
  logic signed [32:0]       acc_nxt;
  logic [11:0]              axr_sum;
  logic [TAB_AW-1:0]        last_ent;
  logic [62:0]              x2_sum;
  logic                     mem_we;

  assign dvsr     = {seg_n, 3'b000};
  assign pshift   = {prem_r, PI32[cnt_r]};
  assign pbit     = pshift >= {1'b0, dvsr};
  assign rc       = term_recip(cos_r, k_r);
  assign tq       = 31'(prod_r >> rc.sh);
  assign acc_nxt  = k_r[0] ? acc_r - $signed({2'b0, tq}) : acc_r + $signed({2'b0, tq});
  assign axr_sum  = axr_r + {1'b0, prem_r};
  assign last_ent = TAB_AW'(seg_n >> 1);
  assign x2_sum   = prod_r + 63'h2000_0000;
  assign mem_we   = (state_r == FS_ACC) && (k_r == 3'd6) && cos_r;
  assign busy     = state_r != FS_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= FS_DIV;
      cnt_r   <= 6'd33;
      prem_r  <= '0;
      pq_r    <= '0;
    end else begin
      unique case (state_r)
        FS_DIV: begin
          prem_r <= pbit ? 11'(pshift - {1'b0, dvsr}) : pshift[10:0];
          pq_r   <= {pq_r[29:0], pbit};
          if (cnt_r == 6'd0) begin
            axq_r   <= '0;
            axr_r   <= {2'b00, seg_n, 2'b00};
            ent_r   <= '0;
            state_r <= FS_X2M;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        FS_X2M: begin
          prod_r  <= {32'b0, axq_r} * {32'b0, axq_r};
          state_r <= FS_X2;
        end
        FS_X2: begin
          x2_r    <= x2_sum[60:30];
          t_r     <= axq_r;
          acc_r   <= $signed({2'b0, axq_r});
          k_r     <= 3'd1;
          cos_r   <= 1'b0;
          state_r <= FS_TM;
        end
        FS_TM: begin
          prod_r  <= {32'b0, t_r} * {32'b0, x2_r};
          state_r <= FS_TL;
        end
        FS_TL: begin
          t_r     <= prod_r[60:30];
          state_r <= FS_TD;
        end
        FS_TD: begin
          prod_r  <= {32'b0, t_r} * {31'b0, rc.m};
          state_r <= FS_ACC;
        end
        FS_ACC: begin
          if (k_r != 3'd6) begin
            acc_r   <= acc_nxt;
            t_r     <= tq;
            k_r     <= k_r + 3'd1;
            state_r <= FS_TM;
          end else if (!cos_r) begin
            sv_r    <= clamp30(acc_nxt);
            t_r     <= ONE30;
            acc_r   <= $signed({2'b0, ONE30});
            k_r     <= 3'd1;
            cos_r   <= 1'b1;
            state_r <= FS_TM;
          end else if (ent_r == last_ent) begin
            state_r <= FS_IDLE;
          end else begin
            ent_r <= ent_r + 1'b1;
            if (axr_sum >= {1'b0, dvsr}) begin
              axr_r <= axr_sum - {1'b0, dvsr};
              axq_r <= axq_r + pq_r + 31'd1;
            end else begin
              axr_r <= axr_sum;
              axq_r <= axq_r + pq_r;
            end
            state_r <= FS_X2M;
          end
        end
        FS_IDLE: begin
          state_r <= FS_IDLE;
        end
        default: begin
          state_r <= FS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ent_r] <= {sv_r, clamp30(acc_nxt)};
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rda_r <= mem[rd.addr_a];
      rdb_r <= mem[rd.addr_b];
    end
  end

  assign rd_data.sin_a = rda_r[2*TRIG_W-1:TRIG_W];
  assign rd_data.cos_a = rda_r[TRIG_W-1:0];
  assign rd_data.sin_b = rdb_r[2*TRIG_W-1:TRIG_W];
  assign rd_data.cos_b = rdb_r[TRIG_W-1:0];

endmodule
`default_nettype wire

>>> rtl/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Maps a ring/pole grid point to its vertex, unit normal and triangle slots.
// ----------------------------------------------------------------------------
// One grid point word is taken per cycle while in_stall is low, and its result
// passes through every stage register to the output; stages hold their words
// under out_stall and empty stages fill, so the input stalls only when every
// stage is full or the table is being built. Sine and cosine come from a table
// built inside the block after reset and after every segment_count write; during
// the build in_stall stays high while configuration writes are still taken.
module uv_sphere_vertex_generator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire uvs_pkg::in_word_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output uvs_pkg::out_word_t              out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [uvs_pkg::CFG_AW-1:0] cfg_index,
  input  wire logic [31:0]                cfg_data
);
  import uvs_pkg::*;

  typedef struct packed {
    logic              neg;
    logic [1:0]        quad;
    logic [TAB_AW-1:0] idx;
  } angle_t;

  typedef struct packed {
    logic [15:0] slot;
    logic        quad;
    logic [15:0] tu;
    logic [15:0] tln;
    logic [15:0] tun;
  } idx_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } pair_t;

  function automatic angle_t angle_split(input logic [8:0] p, input logic [7:0] n);
    logic [10:0]        p4;
    logic [10:0]        n1;
    logic [10:0]        n3;
    logic [10:0]        n5;
    logic [10:0]        n7;
    logic [2:0]         q;
    logic [10:0]        qn;
    logic signed [11:0] s;
    logic [11:0]        mag;
    angle_t             a;
    p4    = {p, 2'b00};
    n1    = {3'b000, n};
    n3    = n1 + {2'b00, n, 1'b0};
    n5    = n1 + {1'b0, n, 2'b00};
    n7    = {n, 3'b000} - n1;
    q     = 3'(p4 >= n1) + 3'(p4 >= n3) + 3'(p4 >= n5) + 3'(p4 >= n7);
    qn    = {8'b0, q} * n1;
    s     = $signed({2'b00, p, 1'b0}) - $signed({1'b0, qn});
    mag   = s[11] ? 12'(-s) : s;
    a.neg  = s[11];
    a.quad = q[1:0];
    a.idx  = mag[TAB_AW-1:0];
    return a;
  endfunction

  function automatic pair_t rotate(input logic [TRIG_W-1:0] sv, input logic [TRIG_W-1:0] cv,
                                   input angle_t a);
    logic signed [31:0] ss;
    logic signed [31:0] cc;
    pair_t              r;
    ss = a.neg ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
    cc = $signed({1'b0, cv});
    unique case (a.quad)
      2'd0: begin r.s = ss;  r.c = cc;  end
      2'd1: begin r.s = cc;  r.c = -ss; end
      2'd2: begin r.s = -ss; r.c = -cc; end
      default: begin r.s = -cc; r.c = ss; end
    endcase
    return r;
  endfunction

  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    return v[31] ? 31'(-v) : v[30:0];
  endfunction

  function automatic logic signed [31:0] round_dir(input logic neg, input logic [61:0] prod);
    logic [61:0] sum;
    sum = prod + 62'h2000_0000;
    return neg ? -$signed({1'b0, sum[60:30]}) : $signed({1'b0, sum[60:30]});
  endfunction

  function automatic logic signed [15:0] normal(input logic signed [31:0] d);
    logic [31:0] sum;
    logic [16:0] nm;
    logic [15:0] r;
    sum = {1'b0, mag31(d)} + 32'h0000_4000;
    nm  = sum[31:15];
    if (d[31]) begin
      r = 16'(17'd0 - nm);
    end else if (nm > 17'd32767) begin
      r = 16'h7FFF;
    end else begin
      r = nm[15:0];
    end
    return $signed(r);
  endfunction

  function automatic logic signed [31:0] vertex(input logic signed [31:0] c, input logic neg,
                                                input logic [61:0] prod);
    logic [61:0]        sum;
    logic signed [33:0] m;
    logic signed [33:0] v;
    logic signed [31:0] r;
    sum = prod + 62'h2000_0000;
    m   = $signed({2'b00, sum[61:30]});
    v   = $signed({{2{c[31]}}, c}) + (neg ? -m : m);
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [SEG_W-1:0]   seg_r;
  logic [30:0]        radius_r;
  logic signed [31:0] cx_r;
  logic signed [31:0] cy_r;
  logic signed [31:0] cz_r;
  logic [SEG_W-1:0]   n_eff;
  logic [30:0]        rad_eff;
  logic               seg_wr;
  logic               busy;

  tab_rd_t            tab_rd;
  tab_data_t          tab_q;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  logic [7:0]         ic;
  logic [7:0]         jc;
  logic [8:0]         n_p1;
  logic [15:0]        slot_nxt;
  angle_t             th1_r;
  angle_t             ph1_r;
  logic [15:0]        slot1_r;
  logic               quad1_r;

  angle_t             th2_r;
  angle_t             ph2_r;
  idx_t               ix2_nxt;
  idx_t               ix2_r;

  pair_t              th_rot;
  pair_t              ph_rot;
  pair_t              t3_r;
  pair_t              p3_r;
  idx_t               ix3_r;

  logic [61:0]        px4_r;
  logic [61:0]        py4_r;
  logic               sx4_r;
  logic               sy4_r;
  logic signed [31:0] dz4_r;
  idx_t               ix4_r;

  logic signed [31:0] dx5_r;
  logic signed [31:0] dy5_r;
  logic signed [31:0] dz5_r;
  idx_t               ix5_r;

  logic [61:0]        vx6_r;
  logic [61:0]        vy6_r;
  logic [61:0]        vz6_r;
  logic               sx6_r;
  logic               sy6_r;
  logic               sz6_r;
  logic signed [15:0] nx6_r;
  logic signed [15:0] ny6_r;
  logic signed [15:0] nz6_r;
  idx_t               ix6_r;

  out_word_t          out_r;

  assign cfg_ready = 1'b1;
  assign seg_wr    = cfg_valid && (cfg_index == REG_SEGMENT_COUNT);
  assign n_eff     = (seg_r == '0) ? SEG_W'(1) :
                     ((seg_r > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : seg_r);
  assign rad_eff   = (radius_r == '0) ? 31'd1 : radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r    <= SEG_W'(16);
      radius_r <= 31'd65536;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEGMENT_COUNT: seg_r    <= cfg_data[SEG_W-1:0];
        REG_RADIUS:        radius_r <= cfg_data[30:0];
        REG_CENTER_X:      cx_r     <= $signed(cfg_data);
        REG_CENTER_Y:      cy_r     <= $signed(cfg_data);
        REG_CENTER_Z:      cz_r     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  uvs_trig_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .seg_n   (n_eff),
    .restart (seg_wr),
    .busy    (busy),
    .rd      (tab_rd),
    .rd_data (tab_q)
  );

  assign en7 = !v7_r || !out_stall;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall = busy || !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid && !busy;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  // clamp indexes, split angles into quadrant and table index
  assign ic       = (in_data.ring_index > n_eff) ? n_eff : in_data.ring_index;
  assign jc       = (in_data.pole_index > n_eff) ? n_eff : in_data.pole_index;
  assign n_p1     = {1'b0, n_eff} + 9'd1;
  assign slot_nxt = ({8'b0, ic} * {7'b0, n_p1}) + {8'b0, jc};

  always_ff @(posedge clk) begin
    if (en1) begin
      th1_r   <= angle_split({ic, 1'b0}, n_eff);
      ph1_r   <= angle_split({1'b0, jc}, n_eff);
      slot1_r <= slot_nxt;
      quad1_r <= (ic < n_eff) && (jc < n_eff);
    end
  end

  // table read; triangle corners
  assign tab_rd.en     = en2;
  assign tab_rd.addr_a = th1_r.idx;
  assign tab_rd.addr_b = ph1_r.idx;

  assign ix2_nxt.slot = slot1_r;
  assign ix2_nxt.quad = quad1_r;
  assign ix2_nxt.tu   = quad1_r ? slot1_r + {7'b0, n_p1} : '0;
  assign ix2_nxt.tln  = quad1_r ? slot1_r + 16'd1 : '0;
  assign ix2_nxt.tun  = quad1_r ? slot1_r + {7'b0, n_p1} + 16'd1 : '0;

  always_ff @(posedge clk) begin
    if (en2) begin
      th2_r <= th1_r;
      ph2_r <= ph1_r;
      ix2_r <= ix2_nxt;
    end
  end

  // quadrant rotation
  assign th_rot = rotate(tab_q.sin_a, tab_q.cos_a, th2_r);
  assign ph_rot = rotate(tab_q.sin_b, tab_q.cos_b, ph2_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      t3_r  <= th_rot;
      p3_r  <= ph_rot;
      ix3_r <= ix2_r;
    end
  end

  // direction products
  always_ff @(posedge clk) begin
    if (en4) begin
      px4_r <= {31'b0, mag31(p3_r.s)} * {31'b0, mag31(t3_r.c)};
      py4_r <= {31'b0, mag31(p3_r.s)} * {31'b0, mag31(t3_r.s)};
      sx4_r <= p3_r.s[31] ^ t3_r.c[31];
      sy4_r <= p3_r.s[31] ^ t3_r.s[31];
      dz4_r <= p3_r.c;
      ix4_r <= ix3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      dx5_r <= round_dir(sx4_r, px4_r);
      dy5_r <= round_dir(sy4_r, py4_r);
      dz5_r <= dz4_r;
      ix5_r <= ix4_r;
    end
  end

  // radius products and normals
  always_ff @(posedge clk) begin
    if (en6) begin
      vx6_r <= {31'b0, rad_eff} * {31'b0, mag31(dx5_r)};
      vy6_r <= {31'b0, rad_eff} * {31'b0, mag31(dy5_r)};
      vz6_r <= {31'b0, rad_eff} * {31'b0, mag31(dz5_r)};
      sx6_r <= dx5_r[31];
      sy6_r <= dy5_r[31];
      sz6_r <= dz5_r[31];
      nx6_r <= normal(dx5_r);
      ny6_r <= normal(dy5_r);
      nz6_r <= normal(dz5_r);
      ix6_r <= ix5_r;
    end
  end

  // offset by center, saturate, hold for the consumer
  always_ff @(posedge clk) begin
    if (en7) begin
      out_r.vertex_x       <= vertex(cx_r, sx6_r, vx6_r);
      out_r.vertex_y       <= vertex(cy_r, sy6_r, vy6_r);
      out_r.vertex_z       <= vertex(cz_r, sz6_r, vz6_r);
      out_r.normal_x       <= nx6_r;
      out_r.normal_y       <= ny6_r;
      out_r.normal_z       <= nz6_r;
      out_r.vertex_slot    <= ix6_r.slot;
      out_r.quad_valid     <= ix6_r.quad;
      out_r.tri_upper      <= ix6_r.tu;
      out_r.tri_lower_next <= ix6_r.tln;
      out_r.tri_upper_next <= ix6_r.tun;
    end
  end

  assign out_valid = v7_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("word accepted during table build");

  a_seg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    seg_wr |=> busy)
    else $error("segment count write did not start table build");

  a_tab_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (tab_q.sin_a <= ONE30) && (tab_q.cos_a <= ONE30) &&
             (tab_q.sin_b <= ONE30) && (tab_q.cos_b <= ONE30))
    else $error("table entry above one");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (dx5_r <= $signed({1'b0, ONE30})) && (dx5_r >= -$signed({1'b0, ONE30})) &&
             (dy5_r <= $signed({1'b0, ONE30})) && (dy5_r >= -$signed({1'b0, ONE30})))
    else $error("direction component out of range");
`endif

endmodule
`default_nettype wire
